### hw/rtl/rpe_pkg.sv
`default_nettype none
package rpe_pkg;

   // Register indexes on the csr port
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CFG_MASS_FIRST  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_MASS_SECOND = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_SEPARATION  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CFG_GRAV_CONST  = 8'd3;

   // Square root: radicand below 2^68, root below 2^34, one root bit per stage
   localparam int RAD_W  = 68;
   localparam int ROOT_W = 34;

   // Dividers resolve 48 quotient bits after one overflow check stage
   localparam int QUO_BITS = 48;
   localparam int DIV_LAT  = QUO_BITS + 1;

   localparam int POT_W = 48;
   localparam logic [POT_W-1:0] POT_LIMIT = 48'h8000_0000_0000;

   typedef enum logic [1:0] {
      DRV_IDLE,
      DRV_MUL,
      DRV_DIV_LOAD,
      DRV_DIV_RUN
   } drv_state_type;

endpackage
`default_nettype wire

### hw/rtl/rpe_sqrt.sv
`default_nettype none
// Pipelined integer square root, floor(sqrt(rad)), one result bit per stage.
module rpe_sqrt (
   input  wire logic                       clock,
   input  wire logic [rpe_pkg::RAD_W-1:0]  rad,
   output logic      [rpe_pkg::ROOT_W-1:0] root
);

   localparam int RW = rpe_pkg::RAD_W;
   localparam int SW = rpe_pkg::ROOT_W;

   logic [RW-1:0] rem_ff [SW];
   logic [RW-1:0] rem_in [SW];
   logic [SW-1:0] res_ff [SW];
   logic [SW-1:0] res_in [SW];

   genvar i;
   for (i = 0; i < SW; i++) begin : g_stage
      localparam int B = SW - 1 - i;
      logic [RW-1:0] rem_prev;
      logic [RW-1:0] trial;
      logic [SW-1:0] res_prev;
      logic          take;

      if (i == 0) begin : g_first
         assign rem_prev = rad;
         assign res_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign res_prev = res_ff[i-1];
      end

      // (res + 2^B)^2 - res^2, res holds only bits above B
      assign trial     = (RW'(res_prev) << (B + 1)) | (RW'(1) << (2 * B));
      assign take      = rem_prev >= trial;
      assign rem_in[i] = take ? (rem_prev - trial) : rem_prev;
      assign res_in[i] = take ? (res_prev | (SW'(1) << B)) : res_prev;

      always_ff @(posedge clock) begin
         rem_ff[i] <= rem_in[i];
         res_ff[i] <= res_in[i];
      end
   end

   assign root = res_ff[SW-1];

endmodule
`default_nettype wire

### hw/rtl/rpe_div.sv
`default_nettype none
// Pipelined restoring divider: 48 quotient bits, sat when quotient >= 2^48.
module rpe_div #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 34
) (
   input  wire logic                         clock,
   input  wire logic [NUM_W-1:0]             num,
   input  wire logic [DEN_W-1:0]             den,
   output logic      [rpe_pkg::QUO_BITS-1:0] quo,
   output logic                              sat
);

   localparam int QB = rpe_pkg::QUO_BITS;
   localparam int WW = DEN_W + QB;

   logic [NUM_W-1:0] rem0_ff;
   logic [DEN_W-1:0] den0_ff;
   logic             sat0_ff;

   logic [NUM_W-1:0] rem_ff [QB];
   logic [NUM_W-1:0] rem_in [QB];
   logic [DEN_W-1:0] den_ff [QB];
   logic [QB-1:0]    quo_ff [QB];
   logic [QB-1:0]    quo_in [QB];
   logic             sat_ff [QB];

   always_ff @(posedge clock) begin
      rem0_ff <= num;
      den0_ff <= den;
      sat0_ff <= WW'(num) >= (WW'(den) << QB);
   end

   genvar i;
   for (i = 0; i < QB; i++) begin : g_stage
      localparam int B = QB - 1 - i;
      logic [NUM_W-1:0] rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [QB-1:0]    quo_prev;
      logic             sat_prev;
      logic [WW-1:0]    trial;
      logic             take;

      if (i == 0) begin : g_first
         assign rem_prev = rem0_ff;
         assign den_prev = den0_ff;
         assign quo_prev = '0;
         assign sat_prev = sat0_ff;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign quo_prev = quo_ff[i-1];
         assign sat_prev = sat_ff[i-1];
      end

      assign trial     = WW'(den_prev) << B;
      assign take      = WW'(rem_prev) >= trial;
      assign rem_in[i] = take ? NUM_W'(WW'(rem_prev) - trial) : rem_prev;
      assign quo_in[i] = take ? (quo_prev | (QB'(1) << B)) : quo_prev;

      always_ff @(posedge clock) begin
         rem_ff[i] <= rem_in[i];
         den_ff[i] <= den_prev;
         quo_ff[i] <= quo_in[i];
         sat_ff[i] <= sat_prev;
      end
   end

   assign quo = quo_ff[QB-1];
   assign sat = sat_ff[QB-1];

endmodule
`default_nettype wire

### hw/rtl/roche_potential_point_eval_core.sv
`default_nettype none
// Channel   Direction  Ports                                   Transfer
// --------  ---------  --------------------------------------  ------------------------------
// request   in         start, busy, req_x_coord, req_y_coord   start & !busy at rising edge
// response  out        rsp_valid, rsp_potential, rsp_singular  rsp_valid, one cycle, no stall
// csr       in         csr_valid, csr_ready, csr_index,        csr_valid & csr_ready
//                      csr_data
//
// One point per cycle while busy is low; a result transfers once its request has passed
// the 88 register stages (4 setup, 34-stage square root, 49-stage divider, 1 output).
// After reset and after every csr transfer a derivation sequencer (8 multiply
// steps on one 32x32 multiplier, then two 32-step divisions for the star
// offsets, each after a load state) holds busy high until it returns to idle.
// Reset is synchronous; it clears the valid line, restarts the sequencer and sets the csr registers to 1.0.
// The response side cannot stall, so the pipeline always advances.
module roche_potential_point_eval_core #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic signed [31:0]              req_x_coord,
   input  wire logic signed [31:0]              req_y_coord,
   // response
   output logic                                 rsp_valid,
   output logic signed [rpe_pkg::POT_W-1:0]     rsp_potential,
   output logic                                 rsp_singular,
   // csr
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [rpe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [31:0]                     csr_data
);

   localparam logic [31:0] ONE_Q   = 32'd1 << FRAC_BITS;
   localparam int          SW      = rpe_pkg::ROOT_W;
   localparam int          QB      = rpe_pkg::QUO_BITS;
   localparam int          DL      = rpe_pkg::DIV_LAT;
   localparam int          C_DLY   = SW - 2;        // centrifugal path starts 2 stages late
   localparam int          VLD_LEN = 4 + SW + DL + 1;

   //--------------------------------------------------------------------------
   // Configuration registers
   //--------------------------------------------------------------------------
   logic [31:0] mass_first_ff, mass_second_ff, separation_ff, grav_const_ff;
   logic        cfg_wr;

   assign csr_ready = 1'b1;
   assign cfg_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_first_ff  <= ONE_Q;
         mass_second_ff <= ONE_Q;
         separation_ff  <= ONE_Q;
         grav_const_ff  <= ONE_Q;
      end else if (cfg_wr) begin
         unique case (csr_index)
            rpe_pkg::CFG_MASS_FIRST:  mass_first_ff  <= csr_data;
            rpe_pkg::CFG_MASS_SECOND: mass_second_ff <= csr_data;
            rpe_pkg::CFG_SEPARATION:  separation_ff  <= csr_data;
            rpe_pkg::CFG_GRAV_CONST:  grav_const_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   //--------------------------------------------------------------------------
   // Derived constants: G*m1, G*m2, G*(m1+m2), 2*a^3 and the star offsets
   //--------------------------------------------------------------------------
   rpe_pkg::drv_state_type state_ff, state_in;
   logic [2:0]  step_ff;
   logic        div_sel_ff;
   logic [4:0]  iter_ff;
   logic [33:0] drem_ff;
   logic [31:0] dq_ff;

   logic [63:0] k1_ff, k2_ff, pa_ff, pb_ff, s2_ff, tlo_ff, thi_ff;
   logic [96:0] den_ff;
   logic [64:0] gm_ff;
   logic [31:0] r1_ff, r2_ff;
   logic [32:0] msum;
   logic        sep_zero;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [34:0] drem_sh;
   logic        dtake;
   logic [31:0] dq_next;

   assign msum     = 33'(mass_first_ff) + 33'(mass_second_ff);
   assign sep_zero = separation_ff == 32'd0;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rpe_pkg::DRV_IDLE:     state_in = rpe_pkg::DRV_IDLE;
         rpe_pkg::DRV_MUL:      if (step_ff == 3'd7) state_in = rpe_pkg::DRV_DIV_LOAD;
         rpe_pkg::DRV_DIV_LOAD: state_in = rpe_pkg::DRV_DIV_RUN;
         rpe_pkg::DRV_DIV_RUN: begin
            if (iter_ff == 5'd31) begin
               state_in = div_sel_ff ? rpe_pkg::DRV_IDLE : rpe_pkg::DRV_DIV_LOAD;
            end
         end
         default: state_in = rpe_pkg::DRV_MUL;
      endcase
      if (cfg_wr) state_in = rpe_pkg::DRV_MUL;
   end

   always_comb begin
      busy  = state_ff != rpe_pkg::DRV_IDLE;
      mul_a = grav_const_ff;
      mul_b = mass_first_ff;
      case (step_ff)
         3'd1: mul_b = mass_second_ff;
         3'd2: begin mul_a = separation_ff; mul_b = mass_second_ff; end
         3'd3: begin mul_a = separation_ff; mul_b = mass_first_ff;  end
         3'd4: begin mul_a = separation_ff; mul_b = separation_ff;  end
         3'd5: begin mul_a = s2_ff[31:0];   mul_b = separation_ff;  end
         3'd6: begin mul_a = s2_ff[63:32];  mul_b = separation_ff;  end
         default: ;
      endcase
   end

   assign mul_p   = 64'(mul_a) * 64'(mul_b);
   assign drem_sh = {drem_ff, dq_ff[31]};
   assign dtake   = drem_sh >= 35'(msum);
   assign dq_next = {dq_ff[30:0], dtake};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rpe_pkg::DRV_MUL;
         step_ff    <= '0;
         div_sel_ff <= 1'b0;
         iter_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (cfg_wr) begin
            step_ff    <= '0;
            div_sel_ff <= 1'b0;
         end else if (state_ff == rpe_pkg::DRV_MUL) begin
            step_ff <= step_ff + 3'd1;
         end else if (state_ff == rpe_pkg::DRV_DIV_LOAD) begin
            iter_ff <= '0;
         end else if (state_ff == rpe_pkg::DRV_DIV_RUN) begin
            iter_ff <= iter_ff + 5'd1;
            if (iter_ff == 5'd31) div_sel_ff <= ~div_sel_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == rpe_pkg::DRV_MUL) begin
         case (step_ff)
            3'd0: k1_ff  <= mul_p;
            3'd1: k2_ff  <= mul_p;
            3'd2: pa_ff  <= mul_p;
            3'd3: pb_ff  <= mul_p;
            3'd4: s2_ff  <= mul_p;
            3'd5: tlo_ff <= mul_p;
            3'd6: thi_ff <= mul_p;
            default: begin
               den_ff <= (97'({thi_ff, 32'd0}) + 97'(tlo_ff)) << 1;
               gm_ff  <= 65'(k1_ff) + 65'(k2_ff);
            end
         endcase
      end
      if (state_ff == rpe_pkg::DRV_DIV_LOAD) begin
         // quotient fits 32 bits, so the upper numerator half is below msum
         drem_ff <= {2'b00, div_sel_ff ? pb_ff[63:32] : pa_ff[63:32]};
         dq_ff   <= div_sel_ff ? pb_ff[31:0] : pa_ff[31:0];
      end
      if (state_ff == rpe_pkg::DRV_DIV_RUN) begin
         drem_ff <= dtake ? 34'(drem_sh - 35'(msum)) : drem_sh[33:0];
         dq_ff   <= dq_next;
         if (iter_ff == 5'd31) begin
            if (div_sel_ff) r2_ff <= (msum == 33'd0) ? 32'd0 : dq_next;
            else            r1_ff <= (msum == 33'd0) ? 32'd0 : dq_next;
         end
      end
   end

   //--------------------------------------------------------------------------
   // Point pipeline
   //--------------------------------------------------------------------------
   logic               accept;
   logic [VLD_LEN-1:0] vld_ff;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= {vld_ff[VLD_LEN-2:0], accept};
   end

   // stage 0: capture
   logic [31:0] x0_ff, y0_ff;
   always_ff @(posedge clock) begin
      x0_ff <= req_x_coord;
      y0_ff <= req_y_coord;
   end

   // stage 1: magnitudes and offsets from each star
   logic [33:0] dx1, dx2;
   logic [31:0] ax1_ff, ay1_ff;
   logic [32:0] ad1_ff, ad2_ff;

   assign dx1 = {{2{x0_ff[31]}}, x0_ff} + {2'b00, r1_ff};
   assign dx2 = {{2{x0_ff[31]}}, x0_ff} - {2'b00, r2_ff};

   always_ff @(posedge clock) begin
      ax1_ff <= x0_ff[31] ? (~x0_ff + 32'd1) : x0_ff;
      ay1_ff <= y0_ff[31] ? (~y0_ff + 32'd1) : y0_ff;
      ad1_ff <= dx1[33] ? 33'(~dx1 + 34'd1) : dx1[32:0];
      ad2_ff <= dx2[33] ? 33'(~dx2 + 34'd1) : dx2[32:0];
   end

   // stage 2: squares
   logic [63:0] axsq_ff, aysq_ff;
   logic [65:0] d1sq_ff, d2sq_ff;
   always_ff @(posedge clock) begin
      axsq_ff <= 64'(ax1_ff) * 64'(ax1_ff);
      aysq_ff <= 64'(ay1_ff) * 64'(ay1_ff);
      d1sq_ff <= 66'(ad1_ff) * 66'(ad1_ff);
      d2sq_ff <= 66'(ad2_ff) * 66'(ad2_ff);
   end

   // stage 3: squared distances and squared radius
   logic [rpe_pkg::RAD_W-1:0] v1_ff, v2_ff;
   logic [63:0]               q_ff;
   always_ff @(posedge clock) begin
      v1_ff <= rpe_pkg::RAD_W'(d1sq_ff) + rpe_pkg::RAD_W'(aysq_ff);
      v2_ff <= rpe_pkg::RAD_W'(d2sq_ff) + rpe_pkg::RAD_W'(aysq_ff);
      q_ff  <= axsq_ff + aysq_ff;
   end

   // distances to the stars
   logic [SW-1:0] s1, s2;
   rpe_sqrt u_sqrt1 (.clock(clock), .rad(v1_ff), .root(s1));
   rpe_sqrt u_sqrt2 (.clock(clock), .rad(v2_ff), .root(s2));

   // gravity terms G*m_i / s_i
   logic [QB-1:0] g1q, g2q;
   logic          g1sat, g2sat;
   rpe_div #(.NUM_W(64), .DEN_W(SW)) u_div_g1 (
      .clock(clock), .num(k1_ff), .den(s1), .quo(g1q), .sat(g1sat)
   );
   rpe_div #(.NUM_W(64), .DEN_W(SW)) u_div_g2 (
      .clock(clock), .num(k2_ff), .den(s2), .quo(g2q), .sat(g2sat)
   );

   // zero distance flag rides alongside the gravity dividers
   logic [DL-1:0] zero_ff;
   always_ff @(posedge clock) begin
      zero_ff <= {zero_ff[DL-2:0], (s1 == '0) || (s2 == '0)};
   end

   // centrifugal term: G*msum*r^2 / (2*a^3), product split in 32-bit limbs
   logic [63:0]  p00_ff, p01_ff;
   logic [64:0]  p10_ff, p11_ff;
   logic [127:0] num_ff;
   always_ff @(posedge clock) begin
      p00_ff <= 64'(gm_ff[31:0]) * 64'(q_ff[31:0]);
      p01_ff <= 64'(gm_ff[31:0]) * 64'(q_ff[63:32]);
      p10_ff <= 65'(gm_ff[64:32]) * 65'(q_ff[31:0]);
      p11_ff <= 65'(gm_ff[64:32]) * 65'(q_ff[63:32]);
      num_ff <= 128'(p00_ff) + (128'(p01_ff) << 32) + (128'(p10_ff) << 32)
                + (128'(p11_ff) << 64);
   end

   logic [QB-1:0] cq;
   logic          csat;
   rpe_div #(.NUM_W(128), .DEN_W(97)) u_div_c (
      .clock(clock), .num(num_ff), .den(den_ff), .quo(cq), .sat(csat)
   );

   logic [C_DLY-1:0][QB-1:0] cq_dly_ff;
   logic [C_DLY-1:0]         csat_dly_ff;
   always_ff @(posedge clock) begin
      cq_dly_ff   <= {cq_dly_ff[C_DLY-2:0], cq};
      csat_dly_ff <= {csat_dly_ff[C_DLY-2:0], csat};
   end

   // output stage: sum, saturate, negate
   logic [QB+1:0]  total;
   logic           fail;
   logic [QB-1:0]  pot_ff;
   logic           sing_ff;

   assign total = (QB+2)'(g1q) + (QB+2)'(g2q) + (QB+2)'(cq_dly_ff[C_DLY-1]);
   assign fail  = zero_ff[DL-1] || sep_zero || g1sat || g2sat || csat_dly_ff[C_DLY-1]
                  || (total > (QB+2)'(rpe_pkg::POT_LIMIT));

   always_ff @(posedge clock) begin
      pot_ff  <= fail ? rpe_pkg::POT_LIMIT : QB'((QB+2)'(0) - total);
      sing_ff <= fail;
   end

   assign rsp_valid     = vld_ff[VLD_LEN-1];
   assign rsp_potential = pot_ff;
   assign rsp_singular  = sing_ff;

   //--------------------------------------------------------------------------
   // Checks
   //--------------------------------------------------------------------------
   a_nonpositive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_singular) |-> (rsp_potential <= 0))
      else $error("non-singular potential is positive");

   a_singular_floor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> (rsp_potential == $signed(rpe_pkg::POT_LIMIT)))
      else $error("singular result not at the negative limit");

   a_cfg_busy: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> busy)
      else $error("csr transfer did not start derivation");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response strobe right after reset");

endmodule
`default_nettype wire

### tb/roche_potential_point_eval_checker.sv
`default_nettype none
module roche_potential_point_eval_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic                                busy,
   input  wire logic signed [31:0]                  req_x_coord,
   input  wire logic signed [31:0]                  req_y_coord,
   input  wire logic                                rsp_valid,
   input  wire logic signed [rpe_pkg::POT_W-1:0]    rsp_potential,
   input  wire logic                                rsp_singular,
   input  wire logic                                csr_valid,
   input  wire logic                                csr_ready,
   input  wire logic [rpe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [31:0]                         csr_data,
   output int                                       mismatches,
   output int                                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [rpe_pkg::POT_W-1:0] potential;
      logic                      singular;
   } point_result_type;

   localparam logic [127:0] SAT_LIM = 128'd1 << 47;

   logic [31:0] mass_a, mass_b, sep_len, gconst;
   point_result_type expected_points[$];

   function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
      logic [63:0]  root;
      logic [63:0]  cand;
      logic [127:0] sq;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         sq = {64'd0, cand} * {64'd0, cand};
         if (v >= sq) root = cand;
      end
      return root;
   endfunction

   function automatic logic [63:0] star_dist(input longint dx, input logic [127:0] ysq);
      logic [63:0] adx;
      adx = (dx < 0) ? 64'(-dx) : 64'(dx);
      return floor_sqrt(({64'd0, adx} * {64'd0, adx}) + ysq);
   endfunction

   function automatic point_result_type eval_potential(input logic signed [31:0] x,
                                                        input logic signed [31:0] y);
      point_result_type res;
      logic [63:0]  msum, off1, off2, ax, ay, d1, d2, rsq;
      logic [127:0] ysq, t1, t2, tc, den, total;
      logic [255:0] num_full;
      logic         ok;
      longint       xs;
      xs   = longint'(x);
      msum = {32'd0, mass_a} + {32'd0, mass_b};
      off1 = '0;
      off2 = '0;
      if (msum != 0) begin
         off1 = ({32'd0, sep_len} * {32'd0, mass_b}) / msum;
         off2 = ({32'd0, sep_len} * {32'd0, mass_a}) / msum;
      end
      ax  = (x < 0) ? 64'(-xs) : 64'(xs);
      ay  = (y < 0) ? 64'(-longint'(y)) : 64'(longint'(y));
      ysq = {64'd0, ay} * {64'd0, ay};
      d1  = star_dist(xs + longint'(off1), ysq);
      d2  = star_dist(xs - longint'(off2), ysq);
      ok  = 1'b0;
      total = '0;
      if (d1 != 0 && d2 != 0 && sep_len != 0) begin
         rsq = ax * ax + ay * ay;
         // the centrifugal numerator keeps only its low 128 bits
         num_full = {224'd0, gconst} * {192'd0, msum} * {192'd0, rsq};
         den = {96'd0, sep_len} * {96'd0, sep_len} * {96'd0, sep_len};
         den = den << 1;
         t1 = ({96'd0, gconst} * {96'd0, mass_a}) / {64'd0, d1};
         t2 = ({96'd0, gconst} * {96'd0, mass_b}) / {64'd0, d2};
         tc = num_full[127:0] / den;
         ok = (t1 <= SAT_LIM) && (t2 <= SAT_LIM) && (tc <= SAT_LIM);
         if (ok) begin
            total = t1 + t2 + tc;
            ok = (total <= SAT_LIM);
         end
      end
      if (ok) begin
         res.potential = rpe_pkg::POT_W'(-total);
         res.singular  = 1'b0;
      end else begin
         res.potential = rpe_pkg::POT_LIMIT;
         res.singular  = 1'b1;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      point_result_type want;
      if (reset) begin
         mass_a <= 32'd1 << 16;
         mass_b <= 32'd1 << 16;
         sep_len <= 32'd1 << 16;
         gconst <= 32'd1 << 16;
         expected_points.delete();
         mismatches <= 0;
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rpe_pkg::CFG_MASS_FIRST:  mass_a <= csr_data;
               rpe_pkg::CFG_MASS_SECOND: mass_b <= csr_data;
               rpe_pkg::CFG_SEPARATION:  sep_len <= csr_data;
               rpe_pkg::CFG_GRAV_CONST:  gconst <= csr_data;
               default: ;
            endcase
         end
         if (start && !busy)
            expected_points.insert(expected_points.size(),
                                   eval_potential(req_x_coord, req_y_coord));
         if (rsp_valid) begin
            if (expected_points.size() == 0) begin
               $error("unexpected result: potential %0d singular %0d", rsp_potential, rsp_singular);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_points.pop_front();
               if (rsp_potential !== want.potential || rsp_singular !== want.singular) begin
                  if (rsp_potential !== want.potential)
                     $error("potential: expected %0d actual %0d",
                            $signed(want.potential), rsp_potential);
                  if (rsp_singular !== want.singular)
                     $error("singular: expected %0d actual %0d", want.singular, rsp_singular);
                  mismatches <= mismatches + 1;
               end
            end
         end
         pending <= expected_points.size();
      end
   end
endmodule
`default_nettype wire

### tb/roche_potential_point_eval_core_test.sv
`default_nettype none
module roche_potential_point_eval_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   // index outside the register map, must be dropped by the block
   localparam logic [rpe_pkg::CSR_IDX_W-1:0] CFG_UNMAPPED = 8'd200;
   localparam int PHASE_ITEMS = 141;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic signed [31:0] req_x_coord = '0;
   logic signed [31:0] req_y_coord = '0;
   logic csr_valid = 1'b0;
   logic [rpe_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic busy, rsp_valid, rsp_singular, csr_ready;
   logic signed [rpe_pkg::POT_W-1:0] rsp_potential;
   int mismatches, pending;
   int idle_pct;
   logic [31:0] cur_sep, cur_ma, cur_mb;

   always #4 clock = ~clock;

   roche_potential_point_eval_core u_dut (.*);
   roche_potential_point_eval_checker u_chk (.*);

   // sender idles each cycle with the phase's idle chance, then holds start until a
   // rising edge with busy low; returns at the next falling edge with start still high
   task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [rpe_pkg::CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == rpe_pkg::CFG_SEPARATION) cur_sep = val;
      if (idx == rpe_pkg::CFG_MASS_FIRST) cur_ma = val;
      if (idx == rpe_pkg::CFG_MASS_SECOND) cur_mb = val;
   endtask

   task automatic drain;
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   task automatic load_config(input logic [31:0] ma, input logic [31:0] mb,
                              input logic [31:0] sep, input logic [31:0] g);
      drain();
      write_reg(rpe_pkg::CFG_MASS_FIRST, ma);
      write_reg(rpe_pkg::CFG_MASS_SECOND, mb);
      write_reg(rpe_pkg::CFG_SEPARATION, sep);
      write_reg(rpe_pkg::CFG_GRAV_CONST, g);
   endtask

   // mostly points around the binary, some near star one, some anywhere
   task automatic send_random_point;
      logic [31:0] span;
      logic signed [31:0] x, y;
      logic [63:0] msum, off;
      int kind;
      kind = $urandom_range(9);
      span = (cur_sep == 0) ? 32'h0002_0000 : ((cur_sep >> 1) + 1);
      x = $signed($urandom_range(span)) * ($urandom_range(1) ? 2 : -2);
      y = $signed($urandom_range(span)) * ($urandom_range(1) ? 2 : -2);
      if (kind < 2) begin
         msum = {32'd0, cur_ma} + cur_mb;
         off = (msum == 0) ? 64'd0 : ({32'd0, cur_sep} * cur_mb) / msum;
         x = -$signed(off[31:0]) + $signed($urandom_range(6)) - 3;
         y = $signed($urandom_range(6)) - 3;
      end else if (kind < 4) begin
         x = $urandom;
         y = $urandom;
      end
      send_point(x, y);
   endtask

   task automatic run_phase(input int pct, input int count);
      idle_pct = pct;
      for (int i = 0; i < count; i++) send_random_point();
   endtask

   initial begin
      cur_ma = 32'h1_0000;
      cur_mb = 32'h1_0000;
      cur_sep = 32'h1_0000;
      idle_pct = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset configuration: stars at x = -0.5 and +0.5
      send_point(32'sh0, 32'sh0);
      send_point(-32'sh8000, 32'sh0);                 // on star one
      send_point(32'sh8000, 32'sh0);                  // on star two
      send_point(32'sh8000, 32'sh1);                  // one LSB from star two
      send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_point(-32'sh8000_0000, -32'sh8000_0000);
      send_point(-32'sh8000_0000, 32'sh7FFF_FFFF);
      send_point(32'sh1, -32'sh1);
      send_point(32'sh0, 32'sh7FFF_FFFF);
      send_point(32'sh5555_5555, -32'sh2AAA_AAAB);
      run_phase(0, PHASE_ITEMS);

      // unmapped index leaves everything as it was
      drain();
      write_reg(CFG_UNMAPPED, 32'hDEAD_BEEF);
      send_point(32'sh0, 32'sh2_0000);
      run_phase(76, PHASE_ITEMS);

      // everything at its maximum: gravity terms saturate near the stars
      load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_point(32'sh0, 32'sh0);
      send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_point(-32'sh8000_0000, 32'sh0);
      run_phase(0, PHASE_ITEMS);

      // zero total mass: both stars at the origin
      load_config(32'h0, 32'h0, 32'h3_0000, 32'h1_0000);
      send_point(32'sh0, 32'sh0);
      send_point(32'sh1_0000, -32'sh1_0000);
      run_phase(33, PHASE_ITEMS);

      // zero separation: every point is singular
      load_config(32'h2_0000, 32'h1_0000, 32'h0, 32'h1_0000);
      send_point(32'sh4_0000, 32'sh4_0000);
      run_phase(76, 40);

      // tight binary, weak gravity
      load_config(32'h0000_0001, 32'h0010_0000, 32'h1, 32'h0);
      run_phase(0, PHASE_ITEMS);

      // sender holds off until the pipeline is empty, then resumes
      drain();
      run_phase(33, 20);

      for (int p = 0; p < 3; p++) begin
         load_config($urandom_range(32'h0100_0000), $urandom_range(32'h0100_0000),
                     $urandom_range(32'h0040_0000, 1), $urandom);
         run_phase((p == 1) ? 76 : 33, PHASE_ITEMS);
      end
      load_config($urandom, $urandom, $urandom | 1, $urandom);
      run_phase(0, PHASE_ITEMS);

      start <= 1'b0;
      @(negedge clock);
      for (int w = 0; w < 5000 && pending != 0; w++) @(negedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("[roche_potential_point_eval_core] OK");
      end else begin
         $display("[roche_potential_point_eval_core] ERROR");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("[roche_potential_point_eval_core] ERROR");
      $finish;
   end
endmodule
`default_nettype wire
